/* rtl/qrs_pkg.sv */
package qrs_pkg;

  // Field widths of the coefficient and result items.
  localparam int CoefWidth = 16;
  localparam int FracBits  = 16;
  localparam int OutWidth  = 34;
  localparam int DiscWidth = 2 * CoefWidth + 2;

  // Square root of d * 4^FracBits: one result bit per cell.
  localparam int RootWidth = DiscWidth / 2 + FracBits;
  localparam int RemWidth  = RootWidth + 2;
  localparam int SqrtCells = RootWidth;

  // Numerator -b * 2^FracBits +/- sqrt, divisor |2a|.
  localparam int NegBWidth = CoefWidth + FracBits + 1;
  localparam int NumWidth  = RootWidth + 2;
  localparam int MagWidth  = NumWidth - 1;
  localparam int DenWidth  = CoefWidth + 1;
  localparam int DivCells  = MagWidth;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic                        valid;
    status_e                     status;
    logic signed [DiscWidth-1:0] disc;
    logic signed [NegBWidth-1:0] neg_b;
    logic [DenWidth-1:0]         den_mag;
    logic                        den_neg;
    logic [DiscWidth-1:0]        dsh;
    logic [RemWidth-1:0]         rem;
    logic [RootWidth-1:0]        root;
  } sqrt_t;

  typedef struct packed {
    logic                        valid;
    status_e                     status;
    logic signed [DiscWidth-1:0] disc;
    logic [DenWidth-1:0]         den_mag;
    logic                        q_neg1;
    logic                        q_neg2;
    logic [DenWidth-1:0]         rem1;
    logic [MagWidth-1:0]         quo1;
    logic [DenWidth-1:0]         rem2;
    logic [MagWidth-1:0]         quo2;
  } div_t;

endpackage

/* rtl/quadratic_root_solver_core.sv */
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// input    | in_valid_i, in_ready_o, coef_a/b/c_i      | in
// output   | out_valid_o, out_ready_i, root_status_o,  | out
//          | discriminant_o, first_root_o, second_root_o|
//
// An item is taken in every cycle that the pipeline advances; it crosses one
// multiplier stage, 33 square-root cells, 34 divider cells, an output stage.
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken, so a stall at the output holds every stage.
// Reset clears only the valid bits of the stages.

// Solves a*x^2 + b*x + c = 0. The first stage forms b*b and a*c. The
// discriminant and the status are then formed and enter a row of square-root
// cells that produce floor(sqrt(d) * 2^FracBits) one bit per cell. The two
// numerators -b*2^FracBits -/+ sqrt are then divided by |2a| in a row of
// divider cells, one quotient bit per cell, both lanes side by side. The
// quotient sign is applied at the output, which gives truncation toward zero.
// A single root needs no separate path: its square root is zero, so the
// first lane already holds -b*2^FracBits / 2a.
module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CoefWidth-1:0] coef_a_i,
  input  logic signed [CoefWidth-1:0] coef_b_i,
  input  logic signed [CoefWidth-1:0] coef_c_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  root_status_o,
  output logic signed [OutWidth-1:0]  discriminant_o,
  output logic signed [OutWidth-1:0]  first_root_o,
  output logic signed [OutWidth-1:0]  second_root_o
);

  logic adv;

  // Product stage.
  logic                          v1_q;
  logic signed [CoefWidth-1:0]   a_q;
  logic signed [CoefWidth-1:0]   b_q;
  logic signed [2*CoefWidth-1:0] bb_q;
  logic signed [2*CoefWidth-1:0] ac_q;

  // Discriminant and set-up of the square root.
  logic signed [DiscWidth-1:0]   disc;
  logic signed [NegBWidth-1:0]   b_ext;
  logic [CoefWidth-1:0]          abs_a;
  status_e                       status;
  sqrt_t                         sq [SqrtCells+1];

  // Numerators and the division.
  logic signed [NumWidth-1:0]    nb;
  logic signed [NumWidth-1:0]    s_ext;
  logic signed [NumWidth-1:0]    n1;
  logic signed [NumWidth-1:0]    n2;
  logic [NumWidth-1:0]           m1;
  logic [NumWidth-1:0]           m2;
  div_t                          dq [DivCells+1];

  // Output register.
  logic [MagWidth-1:0]           r1;
  logic [MagWidth-1:0]           r2;
  logic                          out_valid_q;
  status_e                       status_q;
  logic signed [OutWidth-1:0]    disc_q;
  logic signed [OutWidth-1:0]    first_q;
  logic signed [OutWidth-1:0]    second_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q  <= coef_a_i;
      b_q  <= coef_b_i;
      bb_q <= coef_b_i * coef_b_i;
      ac_q <= coef_a_i * coef_c_i;
    end
  end

  always_comb begin
    disc = {{2{bb_q[2*CoefWidth-1]}}, bb_q} - {ac_q, 2'b00};
    if (a_q == '0) begin
      status = ST_AZERO;
    end else if (disc[DiscWidth-1]) begin
      status = ST_NONE;
    end else if (disc == '0) begin
      status = ST_ONE;
    end else begin
      status = ST_TWO;
    end
    b_ext = {{(NegBWidth-CoefWidth){b_q[CoefWidth-1]}}, b_q};
    abs_a = a_q[CoefWidth-1] ? CoefWidth'(-a_q) : CoefWidth'(a_q);

    sq[0].valid   = v1_q;
    sq[0].status  = status;
    sq[0].disc    = disc;
    sq[0].neg_b   = (-b_ext) <<< FracBits;
    sq[0].den_mag = {abs_a, 1'b0};
    sq[0].den_neg = a_q[CoefWidth-1];
    sq[0].dsh     = disc[DiscWidth-1] ? '0 : disc;
    sq[0].rem     = '0;
    sq[0].root    = '0;
  end

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .in_i   (sq[i]),
      .out_o  (sq[i+1])
    );
  end

  // The magnitudes are below 2^MagWidth, so the top bit of each is dropped.
  always_comb begin
    nb    = {{(NumWidth-NegBWidth){sq[SqrtCells].neg_b[NegBWidth-1]}},
             sq[SqrtCells].neg_b};
    s_ext = {2'b00, sq[SqrtCells].root};
    n1    = nb - s_ext;
    n2    = nb + s_ext;
    m1    = n1[NumWidth-1] ? NumWidth'(-n1) : NumWidth'(n1);
    m2    = n2[NumWidth-1] ? NumWidth'(-n2) : NumWidth'(n2);

    dq[0].valid   = sq[SqrtCells].valid;
    dq[0].status  = sq[SqrtCells].status;
    dq[0].disc    = sq[SqrtCells].disc;
    dq[0].den_mag = sq[SqrtCells].den_mag;
    dq[0].q_neg1  = n1[NumWidth-1] ^ sq[SqrtCells].den_neg;
    dq[0].q_neg2  = n2[NumWidth-1] ^ sq[SqrtCells].den_neg;
    dq[0].rem1    = '0;
    dq[0].quo1    = m1[MagWidth-1:0];
    dq[0].rem2    = '0;
    dq[0].quo2    = m2[MagWidth-1:0];
  end

  for (genvar j = 0; j < DivCells; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .in_i   (dq[j]),
      .out_o  (dq[j+1])
    );
  end

  always_comb begin
    r1 = dq[DivCells].q_neg1 ? -dq[DivCells].quo1 : dq[DivCells].quo1;
    r2 = dq[DivCells].q_neg2 ? -dq[DivCells].quo2 : dq[DivCells].quo2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dq[DivCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= dq[DivCells].status;
      disc_q   <= OutWidth'(dq[DivCells].disc);
      first_q  <= (dq[DivCells].status == ST_TWO || dq[DivCells].status == ST_ONE) ?
                  OutWidth'(r1) : '0;
      second_q <= (dq[DivCells].status == ST_TWO) ? OutWidth'(r2) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign root_status_o  = status_q;
  assign discriminant_o = disc_q;
  assign first_root_o   = first_q;
  assign second_root_o  = second_q;

endmodule

/* rtl/qrs_sqrt_cell.sv */
// One step of the digit-by-digit square root: brings in the next pair of
// bits and decides one bit of the root.
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  sqrt_t in_i,
  output sqrt_t out_o
);

  logic [RemWidth+1:0] rem_ext;
  logic [RemWidth+1:0] trial;
  logic [RemWidth+1:0] diff;
  logic                ge;
  sqrt_t               data_d;
  sqrt_t               data_q;
  logic                valid_q;

  always_comb begin
    rem_ext = {in_i.rem, in_i.dsh[DiscWidth-1 -: 2]};
    trial   = {2'b00, in_i.root, 2'b01};
    ge      = (rem_ext >= trial);
    diff    = rem_ext - trial;
    data_d      = in_i;
    data_d.dsh  = {in_i.dsh[DiscWidth-3:0], 2'b00};
    data_d.rem  = ge ? diff[RemWidth-1:0] : rem_ext[RemWidth-1:0];
    data_d.root = {in_i.root[RootWidth-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

/* rtl/qrs_div_cell.sv */
// One step of restoring division for both root lanes, which share the divisor.
module qrs_div_cell import qrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t in_i,
  output div_t out_o
);

  logic [DenWidth:0] t1;
  logic [DenWidth:0] t2;
  logic [DenWidth:0] dv;
  logic [DenWidth:0] d1;
  logic [DenWidth:0] d2;
  logic              ge1;
  logic              ge2;
  div_t              data_d;
  div_t              data_q;
  logic              valid_q;

  always_comb begin
    dv  = {1'b0, in_i.den_mag};
    t1  = {in_i.rem1, in_i.quo1[MagWidth-1]};
    t2  = {in_i.rem2, in_i.quo2[MagWidth-1]};
    ge1 = (t1 >= dv);
    ge2 = (t2 >= dv);
    d1  = t1 - dv;
    d2  = t2 - dv;
    data_d      = in_i;
    data_d.rem1 = ge1 ? d1[DenWidth-1:0] : t1[DenWidth-1:0];
    data_d.rem2 = ge2 ? d2[DenWidth-1:0] : t2[DenWidth-1:0];
    data_d.quo1 = {in_i.quo1[MagWidth-2:0], ge1};
    data_d.quo2 = {in_i.quo2[MagWidth-2:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    out_o       = data_q;
    out_o.valid = valid_q;
  end

endmodule

/* rtl/qrs_checker.sv */
// Port-level checks of the solver.
module qrs_checker import qrs_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  root_status_o,
  input logic signed [OutWidth-1:0]  discriminant_o,
  input logic signed [OutWidth-1:0]  first_root_o,
  input logic signed [OutWidth-1:0]  second_root_o
);

  // A waiting item is not withdrawn.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item withdrawn before it was taken");

  // Without real roots, or with a zero a, both roots read zero.
  a_no_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_status_o == ST_NONE || root_status_o == ST_AZERO)
    |-> first_root_o == '0 && second_root_o == '0)
    else $error("roots given where there are none");

  // One root means a zero discriminant and an empty second root.
  a_one_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_status_o == ST_ONE
    |-> discriminant_o == '0 && second_root_o == '0)
    else $error("single root status does not match discriminant");

  // Two roots need a positive discriminant; only the discriminant's sign and
  // its difference from zero are checked, not the roots themselves.
  a_two_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_status_o == ST_TWO
    |-> !discriminant_o[OutWidth-1] && discriminant_o != '0)
    else $error("two roots reported for a discriminant that is not positive");

  a_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_status_o == ST_NONE |-> discriminant_o[OutWidth-1])
    else $error("no real roots reported for a discriminant that is not negative");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);

/* bench/tb_quadratic_root_solver_core.sv */
`timescale 1ns / 1ps

// Self-checking bench for the quadratic root solver core. Coefficient items
// are queued by an initial block and offered by a clocked driver; a clocked
// monitor compares every result item with the prediction for the oldest
// coefficient item still waiting, field by field.
module tb_quadratic_root_solver_core;
  import qrs_pkg::*;

  typedef struct {
    logic signed [CoefWidth-1:0] a;
    logic signed [CoefWidth-1:0] b;
    logic signed [CoefWidth-1:0] c;
  } coefs_t;

  typedef struct {
    status_e                    status;
    logic signed [OutWidth-1:0] disc;
    logic signed [OutWidth-1:0] r1;
    logic signed [OutWidth-1:0] r2;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoefWidth-1:0] coef_a_i = '0;
  logic signed [CoefWidth-1:0] coef_b_i = '0;
  logic signed [CoefWidth-1:0] coef_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] root_status_o;
  logic signed [OutWidth-1:0] discriminant_o, first_root_o, second_root_o;

  coefs_t pending_coefs[$];
  roots_t expected_roots[$];
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;        // no idling in the last part of the run
  bit     hold_sink = 1'b0;   // long receiver hold-off in progress
  bit     hold_source = 1'b0; // sender paused until the pipeline drains
  int     src_gap = 0;
  int     sink_gap = 0;
  int     n_two = 0, n_one = 0, n_none = 0, n_azero = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  quadratic_root_solver_core u_dut (.*);

  // Bitwise integer square root of d * 4^FracBits, two bits per step.
  function automatic longint unsigned scaled_sqrt(longint unsigned d);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 31; i >= -FracBits; i--) begin
      pair = (i >= 0) ? ((d >> (2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Predicts status, discriminant and both Q17.16 roots for one item.
  function automatic roots_t solve_roots(coefs_t k);
    roots_t r;
    longint a, b, c, d, neg_b, den, s;
    a = k.a;
    b = k.b;
    c = k.c;
    d = b * b - 4 * a * c;
    neg_b = -b * (longint'(1) << FracBits);
    den = 2 * a;
    r.r1 = '0;
    r.r2 = '0;
    r.disc = d[OutWidth-1:0];
    if (a == 0) begin
      r.status = ST_AZERO;
    end else if (d < 0) begin
      r.status = ST_NONE;
    end else if (d == 0) begin
      // SystemVerilog division truncates toward zero, like the block.
      r.status = ST_ONE;
      r.r1 = OutWidth'(neg_b / den);
    end else begin
      s = longint'(scaled_sqrt(d));
      r.status = ST_TWO;
      r.r1 = OutWidth'((neg_b - s) / den);
      r.r2 = OutWidth'((neg_b + s) / den);
    end
    return r;
  endfunction

  function automatic logic signed [CoefWidth-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return CoefWidth'(int'($urandom_range(0, 15)) - 8);
      1: return CoefWidth'(-32768);
      2: return CoefWidth'(32767);
      default: return CoefWidth'($urandom);
    endcase
  endfunction

  task automatic queue_item(int a, int b, int c);
    coefs_t k;
    k.a = CoefWidth'(a);
    k.b = CoefWidth'(b);
    k.c = CoefWidth'(c);
    pending_coefs.push_back(k);
  endtask

  // Driver: offers the head of the pending queue, with random gaps in
  // bursts. Valid only drops after an acceptance, never while waiting.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_roots.push_back(solve_roots(pending_coefs.pop_front()));
        n_sent++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (hold_source || pending_coefs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 10);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          coef_a_i <= pending_coefs[0].a;
          coef_b_i <= pending_coefs[0].b;
          coef_c_i <= pending_coefs[0].c;
        end
      end
    end
  end

  // Monitor and receiver: checks each result item and drives the stalls.
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        idle_cycles = 0;
        n_checked++;
        if (expected_roots.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          n_errors++;
        end else begin
          e = expected_roots.pop_front();
          case (e.status)
            ST_TWO: n_two++;
            ST_ONE: n_one++;
            ST_NONE: n_none++;
            default: n_azero++;
          endcase
          if (root_status_o !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, root_status_o);
            n_errors++;
          end
          if (discriminant_o !== e.disc) begin
            $display("%0t: discriminant expected %0d actual %0d", $time, e.disc,
                     discriminant_o);
            n_errors++;
          end
          if (first_root_o !== e.r1) begin
            $display("%0t: first root expected %0d actual %0d", $time, e.r1, first_root_o);
            n_errors++;
          end
          if (second_root_o !== e.r2) begin
            $display("%0t: second root expected %0d actual %0d", $time, e.r2,
                     second_root_o);
            n_errors++;
          end
        end
      end else if (!(in_valid_i && in_ready_o)) begin
        idle_cycles++;
      end
      if (hold_sink) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (idle_cycles > 2000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int extremes[5] = '{-32768, -1, 0, 1, 32767};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two roots, one root, no roots, degenerate a and extremes.
    queue_item(1, -3, 2);
    queue_item(1, 2, 1);
    queue_item(4, 4, 1);
    queue_item(-3, 5, -7);
    queue_item(1, 1, 1);
    queue_item(2, 3, -1);
    queue_item(0, 5, 3);
    queue_item(0, 0, 0);
    queue_item(-1, 0, 9);
    queue_item(3, 0, 0);
    foreach (extremes[i]) queue_item(extremes[i], extremes[(i + 2) % 5], extremes[(i + 4) % 5]);
    queue_item(-32768, -32768, 32767);
    queue_item(32767, -32768, -32768);
    queue_item(-32768, 32767, -32768);
    queue_item(32767, 32767, 32767);
    queue_item(-32768, -32768, -32768);
    wait (n_sent == pending_coefs.size() + n_sent && pending_coefs.size() == 0);

    // Sender pause: wait for the pipeline to drain completely.
    hold_source = 1'b1;
    wait (expected_roots.size() == 0);
    hold_source = 1'b0;

    // Long receiver hold-off while the sender keeps offering items.
    for (int i = 0; i < 150; i++) queue_item(rand_coef(), rand_coef(), rand_coef());
    hold_sink = 1'b1;
    for (int i = 0; i < 200; i++) begin
      @(posedge clk_i);
      idle_cycles = 0;
    end
    hold_sink = 1'b0;

    // Random part; perfect squares now and then give one-root items.
    for (int i = 0; i < 950; i++) begin
      int a, b, c;
      if (i == 800) begin
        wait (pending_coefs.size() == 0);
        calm = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(1, 181) * ($urandom_range(0, 1) ? 1 : -1);
        b = 2 * a * ($urandom_range(0, 80) - 40);
        if (b > 32767 || b < -32768) b = 2 * a;
        c = (b / (2 * a)) * (b / (2 * a)) * a;
        if (c > 32767 || c < -32768) c = a;
        queue_item(a, b, c);
      end else begin
        queue_item(rand_coef(), rand_coef(), rand_coef());
      end
    end
    wait (pending_coefs.size() == 0 && !in_valid_i);
    wait (expected_roots.size() == 0);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d items: %0d two-root, %0d one-root, %0d no-root, %0d a-zero.",
             n_checked, n_two, n_one, n_none, n_azero);
    if (n_errors == 0 && expected_roots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_core.sv
rtl/qrs_checker.sv
bench/tb_quadratic_root_solver_core.sv
